@@ src/smf_pkg.sv @@
// Shared constants and types for the substring match finder.
package smf_pkg;

   localparam int PATTERN_MAX = 16;
   localparam int TEXT_MAX    = 65536;

   localparam int BYTE_W      = 8;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int PLEN_W      = 5;
   localparam int COUNT_W     = 16;
   localparam int START_W     = 16;
   localparam int END_W       = 17;
   localparam int POS_W       = $clog2(TEXT_MAX + 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LEN  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_MATCHES  = 2'd3;

   typedef logic [PATTERN_MAX-1:0][BYTE_W-1:0] window_type;
   typedef logic [15:0][BYTE_W-1:0]            pattern_type;

endpackage

@@ src/smf_req_if.sv @@
// Input channel carrying one text byte per transaction.
interface smf_req_if;
   import smf_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

@@ src/smf_rsp_if.sv @@
// Result channel carrying one match or end-of-text report per transaction.
interface smf_rsp_if;
   import smf_pkg::*;

   logic               valid;
   logic               ready;
   logic               match_found;
   logic [START_W-1:0] start_index;
   logic [END_W-1:0]   end_index;
   logic               text_done;
   logic [COUNT_W-1:0] match_total;

   modport source (output valid, output match_found, output start_index, output end_index,
                   output text_done, output match_total, input ready);
   modport sink   (input valid, input match_found, input start_index, input end_index,
                   input text_done, input match_total, output ready);
endinterface

@@ src/smf_window_cmp.sv @@
// Parallel compare of the byte window against the pattern at the active length.
module smf_window_cmp (
   input  smf_pkg::window_type          window,
   input  smf_pkg::pattern_type         pattern,
   input  logic [smf_pkg::PLEN_W-1:0]   length,
   output logic                         equal
);
   import smf_pkg::*;

   logic [PLEN_W-1:0] offset;

   always_comb begin
      equal  = 1'b1;
      offset = '0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         if (PLEN_W'(k) < length) begin
            offset = length - PLEN_W'(1) - PLEN_W'(k);
            if (pattern[k] != window[offset[$clog2(PATTERN_MAX)-1:0]]) begin
               equal = 1'b0;
            end
         end
      end
   end
endmodule

@@ src/substring_match_finder.sv @@
// Top level of the substring match finder: registers, window, match control and result stage.
// A match or end-of-text result of an accepted byte is registered in the output register.
// One byte per cycle unless stalled; the single window compare and output register set it.
// A byte is taken while a result waits, as long as that result leaves in the same cycle.
// Reset (synchronous, active high) clears the window, position, counts and output valid,
// and loads the register defaults: empty pattern, length 1, max matches 65535.
module substring_match_finder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [smf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [smf_pkg::CSR_DATA_W-1:0]  csr_write_data,
   smf_req_if.sink                        req_if,
   smf_rsp_if.source                      rsp_if
);
   import smf_pkg::*;

   logic [63:0]        pattern_low_ff;
   logic [63:0]        pattern_high_ff;
   logic [PLEN_W-1:0]  pattern_length_ff;
   logic [COUNT_W-1:0] max_matches_ff;

   window_type         window_ff, window_in;
   logic [POS_W-1:0]   byte_position_ff, byte_position_in;
   logic [POS_W-1:0]   earliest_ff, earliest_in;
   logic [COUNT_W-1:0] matches_ff, matches_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               match_found_ff, match_found_in;
   logic [START_W-1:0] start_index_ff, start_index_in;
   logic [END_W-1:0]   end_index_ff, end_index_in;
   logic               text_done_ff, text_done_in;
   logic [COUNT_W-1:0] match_total_ff, match_total_in;

   logic               accept;
   logic               active;
   logic [PLEN_W-1:0]  len_sat;
   logic [POS_W:0]     pos_plus;
   logic [POS_W-1:0]   start_pos;
   logic [POS_W-1:0]   end_pos;
   logic               room;
   logic               equal;
   logic               found;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign len_sat   = (pattern_length_ff > PLEN_W'(PATTERN_MAX)) ? PLEN_W'(PATTERN_MAX)
                                                                 : pattern_length_ff;
   assign active    = byte_position_ff < POS_W'(TEXT_MAX);
   assign pos_plus  = {1'b0, byte_position_ff} + (POS_W+1)'(1);
   assign room      = pos_plus >= (POS_W+1)'(len_sat);
   assign start_pos = POS_W'(pos_plus - (POS_W+1)'(len_sat));
   assign end_pos   = start_pos + POS_W'(len_sat);
   assign window_in = {window_ff[PATTERN_MAX-2:0], req_if.text_byte};

   smf_window_cmp u_window_cmp (
      .window  (window_in),
      .pattern ({pattern_high_ff, pattern_low_ff}),
      .length  (len_sat),
      .equal   (equal)
   );

   assign found = active && (len_sat != '0) && room && equal
                  && (start_pos >= earliest_ff) && (matches_ff < max_matches_ff);

   always_comb begin
      byte_position_in = byte_position_ff;
      earliest_in      = earliest_ff;
      matches_in       = matches_ff;
      if (found) begin
         earliest_in = end_pos;
         matches_in  = matches_ff + COUNT_W'(1);
      end
      if (active) begin
         byte_position_in = byte_position_ff + POS_W'(1);
      end
   end

   always_comb begin
      match_found_in = found;
      start_index_in = found ? START_W'(start_pos) : '0;
      end_index_in   = found ? END_W'(end_pos) : '0;
      text_done_in   = req_if.end_of_text;
      match_total_in = matches_in;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      if (accept && (found || req_if.end_of_text)) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= PLEN_W'(1);
         max_matches_ff    <= '1;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PATTERN_LOW:  pattern_low_ff    <= csr_write_data;
            CSR_PATTERN_HIGH: pattern_high_ff   <= csr_write_data;
            CSR_PATTERN_LEN:  pattern_length_ff <= csr_write_data[PLEN_W-1:0];
            CSR_MAX_MATCHES:  max_matches_ff    <= csr_write_data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff        <= '0;
         byte_position_ff <= '0;
         earliest_ff      <= '0;
         matches_ff       <= '0;
      end else if (accept) begin
         if (req_if.end_of_text) begin
            window_ff        <= '0;
            byte_position_ff <= '0;
            earliest_ff      <= '0;
            matches_ff       <= '0;
         end else if (active) begin
            window_ff        <= window_in;
            byte_position_ff <= byte_position_in;
            earliest_ff      <= earliest_in;
            matches_ff       <= matches_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (found || req_if.end_of_text)) begin
         match_found_ff <= match_found_in;
         start_index_ff <= start_index_in;
         end_index_ff   <= end_index_in;
         text_done_ff   <= text_done_in;
         match_total_ff <= match_total_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.match_found = match_found_ff;
   assign rsp_if.start_index = start_index_ff;
   assign rsp_if.end_index   = end_index_ff;
   assign rsp_if.text_done   = text_done_ff;
   assign rsp_if.match_total = match_total_ff;

   a_next_start_behind_position: assert property (@(posedge clock) disable iff (reset)
      earliest_ff <= byte_position_ff)
      else $error("next allowed start runs ahead of byte position");

   a_position_bounded: assert property (@(posedge clock) disable iff (reset)
      byte_position_ff <= POS_W'(TEXT_MAX))
      else $error("byte position past text limit");

   a_eot_clears_text: assert property (@(posedge clock) disable iff (reset)
      accept && req_if.end_of_text |=> byte_position_ff == '0 && matches_ff == '0)
      else $error("end of text did not clear per-text state");

   a_no_match_zero_indices: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !match_found_ff |-> start_index_ff == '0 && end_index_ff == '0)
      else $error("indices set on a result without a match");

   a_result_has_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> match_found_ff || text_done_ff)
      else $error("result with neither match nor end of text");
endmodule
